// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the command line admission filter modules.
// Depends on nothing; modules that assert include this header by name.
// In simulation each macro is a concurrent assertion reporting via $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Assertion on an explicit clock and active-low reset.
`define CLCAF_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock clk_i and reset rst_ni.
`define CLCAF_ASSERT(label, prop, msg) \
  `CLCAF_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`else

`define CLCAF_ASSERT_CLK(label, clk, rstn, prop, msg)
`define CLCAF_ASSERT(label, prop, msg)

`endif

`endif

// ----- hdl/clcaf_pkg.sv -----
// Types and constants of the command line admission filter.
// Depends on nothing; every module of the block imports it.
package clcaf_pkg;

  // Width of the byte counter and of the trim position.
  localparam int unsigned COUNT_WIDTH = 12;
  // Width of the configuration registers and of the reported length.
  localparam int unsigned REG_WIDTH   = 12;
  // Width used to compare counts against register values.
  localparam int unsigned CMP_WIDTH   = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Byte values that matter to the checks.
  localparam logic [7:0] BYTE_NUL      = 8'h00;
  localparam logic [7:0] BYTE_SPACE    = 8'h20;
  localparam logic [7:0] BYTE_DEL      = 8'h7f;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_WIDTH = 1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_BUFFER_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_LINE_BYTES  = 1'b1;

  localparam logic [REG_WIDTH-1:0] BUFFER_CAPACITY_RST = REG_WIDTH'(256);
  localparam logic [REG_WIDTH-1:0] MAX_LINE_BYTES_RST  = REG_WIDTH'(255);

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_NUL      = 3'd3,
    ST_CONTROL  = 3'd4,
    ST_INVALID  = 3'd5
  } status_e;

  // First fault seen in the current line.
  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_NUL     = 2'd1,
    FAULT_CONTROL = 2'd2
  } fault_e;

  // One input transaction.
  typedef struct packed {
    logic [7:0] line_byte;
    logic       has_byte;
    logic       last;
  } item_t;

  // One result transaction.
  typedef struct packed {
    status_e              status;
    logic [REG_WIDTH-1:0] text_length;
  } result_t;

  // Configuration values seen by the line checker.
  typedef struct packed {
    logic [REG_WIDTH-1:0] buffer_capacity;
    logic [REG_WIDTH-1:0] max_line_bytes;
  } cfg_t;

endpackage

// ----- hdl/clcaf_in_stage.sv -----
// Input register of the admission filter: holds one accepted transaction.
// Depends on clcaf_pkg for the item type.
module clcaf_in_stage
  import clcaf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  output item_t item_o,
  input  logic  advance_i
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;

  // The register takes a new transaction when empty or when it drains now.
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (ready_o) begin
      valid_d = valid_i;
      if (valid_i) begin
        item_d = item_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- hdl/clcaf_line_track.sv -----
// Per-line state of the admission filter and the status decision at line end.
// Depends on clcaf_pkg and on assert_macros.svh.
`include "assert_macros.svh"

module clcaf_line_track
  import clcaf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  logic    advance_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  logic [COUNT_WIDTH-1:0] byte_count_q, byte_count_d;
  logic [COUNT_WIDTH-1:0] content_end_q, content_end_d;
  fault_e                 byte_fault_q, byte_fault_d;

  logic [COUNT_WIDTH-1:0] count_upd;
  logic [COUNT_WIDTH-1:0] end_upd;
  fault_e                 fault_upd;
  logic                   too_long;

  // Fold the current byte into the line state.
  always_comb begin
    count_upd = byte_count_q;
    fault_upd = byte_fault_q;
    end_upd   = content_end_q;
    if (item_i.has_byte) begin
      if (byte_count_q != COUNT_MAX) begin
        count_upd = byte_count_q + COUNT_WIDTH'(1);
      end
      if (byte_fault_q == FAULT_NONE) begin
        if (item_i.line_byte == BYTE_NUL) begin
          fault_upd = FAULT_NUL;
        end else if ((item_i.line_byte < BYTE_SPACE) || (item_i.line_byte == BYTE_DEL)) begin
          fault_upd = FAULT_CONTROL;
        end
      end
      if (item_i.line_byte != BYTE_SPACE) begin
        end_upd = count_upd;
      end
    end
  end

  // Status by precedence, from the state including the last byte.
  assign too_long = (CMP_WIDTH'(count_upd) >= CMP_WIDTH'(cfg_i.buffer_capacity)) ||
                    (CMP_WIDTH'(count_upd) >  CMP_WIDTH'(cfg_i.max_line_bytes)) ||
                    (count_upd == COUNT_MAX);

  always_comb begin
    result_o.text_length = '0;
    if (cfg_i.buffer_capacity == '0) begin
      result_o.status = ST_INVALID;
    end else if (too_long) begin
      result_o.status = ST_TOO_LONG;
    end else if (fault_upd == FAULT_NUL) begin
      result_o.status = ST_NUL;
    end else if (fault_upd == FAULT_CONTROL) begin
      result_o.status = ST_CONTROL;
    end else if (end_upd == '0) begin
      result_o.status = ST_EMPTY;
    end else begin
      result_o.status      = ST_OK;
      result_o.text_length = REG_WIDTH'(end_upd);
    end
  end

  // The line state clears after its last transaction.
  always_comb begin
    byte_count_d  = byte_count_q;
    content_end_d = content_end_q;
    byte_fault_d  = byte_fault_q;
    if (advance_i) begin
      if (item_i.last) begin
        byte_count_d  = '0;
        content_end_d = '0;
        byte_fault_d  = FAULT_NONE;
      end else begin
        byte_count_d  = count_upd;
        content_end_d = end_upd;
        byte_fault_d  = fault_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= '0;
      content_end_q <= '0;
      byte_fault_q  <= FAULT_NONE;
    end else begin
      byte_count_q  <= byte_count_d;
      content_end_q <= content_end_d;
      byte_fault_q  <= byte_fault_d;
    end
  end

  `CLCAF_ASSERT(a_end_within_count, content_end_q <= byte_count_q,
                "trim position beyond byte count")
  `CLCAF_ASSERT(a_no_fault_without_bytes,
                (byte_count_q == '0) |-> (byte_fault_q == FAULT_NONE),
                "fault recorded with no bytes")
  `CLCAF_ASSERT(a_clear_after_last, (advance_i && item_i.last) |=>
                (byte_count_q == '0 && content_end_q == '0),
                "line state not cleared after last transaction")

endmodule

// ----- hdl/clcaf_out_stage.sv -----
// Result register of the admission filter toward the output stream.
// Depends on clcaf_pkg and on assert_macros.svh.
`include "assert_macros.svh"

module clcaf_out_stage
  import clcaf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q, result_d;

  // The register can load when empty or when its result leaves now.
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d  = valid_q;
    result_d = result_q;
    if (load_i) begin
      valid_d  = 1'b1;
      result_d = result_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

  `CLCAF_ASSERT(a_load_only_when_free, load_i |-> free_o,
                "result loaded over a pending result")
  `CLCAF_ASSERT(a_length_only_when_ok,
                valid_q |-> ((result_q.status == ST_OK) == (result_q.text_length != '0)),
                "length and status disagree")

endmodule

// ----- hdl/command_line_admission_filter.sv -----
// Top level of the command line admission filter.
// Depends on clcaf_pkg, clcaf_in_stage, clcaf_line_track and clcaf_out_stage.
//
//   Channel   Direction  Contents
//   s_axis    in         tdata: line_byte; tuser: has_byte; tlast: last
//   m_axis    out        tdata: status, text_length; one transaction per line
//   cfg       in         write enable, register index, 12-bit data
//
// Each transaction passes through the line checker; the input
// register accepts a new transaction every cycle while results drain.
// A line's result is loaded into the result register as its last transaction leaves the input register.
// A last transaction waits in the input register while the result register
// holds an untaken result; other transactions never wait on the output.
// Reset clears the line state and loads the register reset values.
module command_line_admission_filter
  import clcaf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,  // [7:0] line_byte
  input  logic                     s_axis_tuser,  // [0] has_byte
  input  logic                     s_axis_tlast,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [15:0]              m_axis_tdata,  // [2:0] status, [14:3] text_length, [15] zero
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [REG_WIDTH-1:0]     cfg_data_i
);

  cfg_t    cfg_q;
  item_t   in_item;
  item_t   cur_item;
  logic    cur_valid;
  logic    advance;
  logic    out_free;
  result_t line_result;
  result_t out_result;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.buffer_capacity <= BUFFER_CAPACITY_RST;
      cfg_q.max_line_bytes  <= MAX_LINE_BYTES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BUFFER_CAPACITY: cfg_q.buffer_capacity <= cfg_data_i;
        CFG_MAX_LINE_BYTES:  cfg_q.max_line_bytes  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item.line_byte = s_axis_tdata;
  assign in_item.has_byte  = s_axis_tuser;
  assign in_item.last      = s_axis_tlast;

  clcaf_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .valid_o   (cur_valid),
    .item_o    (cur_item),
    .advance_i (advance)
  );

  // A held transaction moves on unless it ends a line and the result slot is busy.
  assign advance = cur_valid && (!cur_item.last || out_free);

  clcaf_line_track u_line_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (cur_item),
    .advance_i (advance),
    .cfg_i     (cfg_q),
    .result_o  (line_result)
  );

  clcaf_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && cur_item.last),
    .result_i (line_result),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {1'b0, out_result.text_length, out_result.status};

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the command line admission filter.
// Depends on clcaf_pkg and command_line_admission_filter; a scoreboard class predicts
// the status and trimmed length of each line and checks every result transaction.
module testbench;
  import clcaf_pkg::*;

  // Predicts line results from accepted input transactions and checks the output.
  class line_scoreboard;
    logic [REG_WIDTH-1:0]   capacity;
    logic [REG_WIDTH-1:0]   max_bytes;
    logic [COUNT_WIDTH-1:0] count;
    logic [COUNT_WIDTH-1:0] content_end;
    fault_e                 fault;
    result_t                expected_q[$];
    int unsigned            failures;
    int unsigned            lines_checked;
    int unsigned            status_seen[6];

    function new();
      capacity  = BUFFER_CAPACITY_RST;
      max_bytes = MAX_LINE_BYTES_RST;
      clear_line();
    endfunction

    function void clear_line();
      count       = '0;
      content_end = '0;
      fault       = FAULT_NONE;
    endfunction

    function void write_register(logic [CFG_IDX_WIDTH-1:0] idx, logic [REG_WIDTH-1:0] value);
      if (idx == CFG_BUFFER_CAPACITY) begin
        capacity = value;
      end else if (idx == CFG_MAX_LINE_BYTES) begin
        max_bytes = value;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Update the line state with one accepted input; queue a result on the last one.
    function void note_item(logic [7:0] b, logic has, logic last);
      result_t want;
      if (has) begin
        if (count != COUNT_MAX) count++;
        if (fault == FAULT_NONE) begin
          if (b == BYTE_NUL) begin
            fault = FAULT_NUL;
          end else if (b < BYTE_SPACE || b == BYTE_DEL) begin
            fault = FAULT_CONTROL;
          end
        end
        if (b != BYTE_SPACE) content_end = count;
      end
      if (!last) return;

      // Status precedence follows the order of these branches.
      want.text_length = '0;
      if (capacity == '0) begin
        want.status = ST_INVALID;
      end else if (CMP_WIDTH'(count) >= CMP_WIDTH'(capacity) ||
                   CMP_WIDTH'(count) > CMP_WIDTH'(max_bytes) || count == COUNT_MAX) begin
        want.status = ST_TOO_LONG;
      end else if (fault == FAULT_NUL) begin
        want.status = ST_NUL;
      end else if (fault == FAULT_CONTROL) begin
        want.status = ST_CONTROL;
      end else if (content_end == '0) begin
        want.status = ST_EMPTY;
      end else begin
        want.status      = ST_OK;
        want.text_length = REG_WIDTH'(content_end);
      end
      expected_q.push_back(want);
      clear_line();
    endfunction

    // Compare one result transaction with the oldest predicted result.
    function void check_result(logic [15:0] data);
      result_t              want;
      status_e              got_status;
      logic [REG_WIDTH-1:0] got_len;
      got_status = status_e'(data[2:0]);
      got_len    = data[14:3];
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("error: result status %0d length %0d with no line pending",
                   data[2:0], got_len);
        end
        return;
      end
      want = expected_q.pop_front();
      lines_checked++;
      status_seen[int'(want.status)]++;
      if (got_status !== want.status || got_len !== want.text_length || data[15] !== 1'b0) begin
        failures++;
        if (failures <= 10) begin
          $display("error: line %0d expected status %0d length %0d, got status %0d length %0d pad %b",
                   lines_checked, want.status, want.text_length, data[2:0], got_len, data[15]);
        end
      end
    endfunction
  endclass

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     s_axis_tvalid  = 1'b0;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata   = '0;
  logic                     s_axis_tuser   = 1'b0;
  logic                     s_axis_tlast   = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready  = 1'b0;
  logic [15:0]              m_axis_tdata;
  logic                     cfg_we_i       = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index_i    = '0;
  logic [REG_WIDTH-1:0]     cfg_data_i     = '0;

  line_scoreboard sb = new();
  bit             idling_on  = 1'b1;
  int unsigned    drain_hold = 0;
  int unsigned    sent_items = 0;

  command_line_admission_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock with a period of 10 time units.
  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // Timeout for a run that hangs.
  initial begin
    #6000000;
    $display("tb: failure");
    $finish;
  end

  // Watch both channels at the rising edge and hand transactions to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
      end
    end
  end

  // Result receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int unsigned stall;
    forever begin
      @(negedge clk_i);
      if (drain_hold != 0) begin
        m_axis_tready <= 1'b0;
        drain_hold--;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 10);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Printable or high byte, never a space or a fault.
  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 4) == 0) begin
      return 8'($urandom_range(8'h80, 8'hff));
    end
    return 8'($urandom_range(BYTE_SPACE + 1, BYTE_DEL - 1));
  endfunction

  // NUL, DEL or another control byte.
  function automatic logic [7:0] fault_byte();
    case ($urandom_range(0, 2))
      0:       return BYTE_NUL;
      1:       return BYTE_DEL;
      default: return 8'($urandom_range(1, BYTE_SPACE - 1));
    endcase
  endfunction

  // Offer one input transaction, after an optional gap, and wait for its handshake.
  task automatic send_item(input logic [7:0] b, input logic has, input logic last);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= has;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    sent_items++;
  endtask

  // Write a register once all results are in and the pipeline has drained.
  task automatic write_register(input logic [CFG_IDX_WIDTH-1:0] idx,
                                input logic [REG_WIDTH-1:0] value);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_register(idx, value);
  endtask

  // One random line: text, optional trailing spaces and faults, ignored items mixed in.
  task automatic send_random_line();
    int          edge_len;
    int          len;
    int          trail;
    int          fault_pos;
    int unsigned pick;
    logic [7:0]  b;
    bit          marker_end;
    bit          all_space;
    bit          with_fault;
    // Aim some lengths at the point where a line becomes too long.
    edge_len = (int'(sb.capacity) <= int'(sb.max_bytes)) ? int'(sb.capacity)
                                                         : int'(sb.max_bytes) + 1;
    pick = $urandom_range(0, 99);
    if (pick < 20 && edge_len <= 64) begin
      len = edge_len + int'($urandom_range(0, 2)) - 1;
      if (len < 0) len = 0;
    end else if (pick < 85) begin
      len = $urandom_range(0, 16);
    end else begin
      len = $urandom_range(17, 70);
    end
    trail      = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 4)) : 0;
    if (trail > len) trail = len;
    with_fault = ($urandom_range(0, 7) == 0);
    fault_pos  = (len > 0) ? int'($urandom_range(0, len - 1)) : 0;
    all_space  = ($urandom_range(0, 19) == 0);
    marker_end = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int k = 0; k < len; k++) begin
      if (all_space || k >= len - trail || $urandom_range(0, 9) == 0) begin
        b = BYTE_SPACE;
      end else begin
        b = text_byte();
      end
      if (with_fault && (k == fault_pos || $urandom_range(0, 15) == 0)) b = fault_byte();
      if ($urandom_range(0, 29) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(b, 1'b1, !marker_end && k == len - 1);
    end
    if (marker_end) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // A phase of random lines under one register setting.
  task automatic run_phase(input logic [REG_WIDTH-1:0] cap, input logic [REG_WIDTH-1:0] maxb,
                           input int unsigned budget);
    int unsigned start;
    write_register(CFG_BUFFER_CAPACITY, cap);
    write_register(CFG_MAX_LINE_BYTES, maxb);
    start = sent_items;
    while (sent_items - start < budget) send_random_line();
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed lines under the reset register values.
    send_item(8'h00, 1'b0, 1'b1);           // empty end marker alone: empty
    send_item("A", 1'b1, 1'b1);             // single byte: ok, length 1
    send_item(8'hff, 1'b1, 1'b0);           // high bytes are text
    send_item(8'h80, 1'b1, 1'b1);
    send_item("a", 1'b1, 1'b0);             // trailing spaces are trimmed
    send_item(BYTE_SPACE, 1'b1, 1'b0);
    send_item(BYTE_SPACE, 1'b1, 1'b1);
    send_item(BYTE_SPACE, 1'b1, 1'b1);      // only a space: empty
    send_item(BYTE_NUL, 1'b1, 1'b0);        // NUL before a control byte: NUL
    send_item(8'h01, 1'b1, 1'b1);
    send_item(8'h1f, 1'b1, 1'b0);           // control byte before NUL: control
    send_item(BYTE_NUL, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b1);
    send_item(BYTE_DEL, 1'b1, 1'b1);        // DEL counts as a control byte
    send_item("b", 1'b1, 1'b0);             // ignored item inside a line
    send_item(8'haa, 1'b0, 1'b0);
    send_item("c", 1'b1, 1'b1);
    send_item(BYTE_SPACE, 1'b1, 1'b0);      // leading space is kept
    send_item("x", 1'b1, 1'b1);
    s_axis_tvalid <= 1'b0;

    // Random phases over several register settings, extremes included.
    run_phase('0, MAX_LINE_BYTES_RST, 60);
    run_phase(REG_WIDTH'(1), '0, 140);
    run_phase('1, '0, 140);
    run_phase('1, '1, 140);
    // Start the long receiver hold-off only once the block is empty, so that it
    // overlaps the next phase's traffic and the input stalls.
    while (sb.pending() != 0) @(posedge clk_i);
    drain_hold = 300;
    run_phase(REG_WIDTH'($urandom_range(1, 40)), REG_WIDTH'($urandom_range(0, 40)), 140);
    run_phase(REG_WIDTH'($urandom_range(1, 40)), REG_WIDTH'($urandom_range(0, 40)), 140);
    run_phase(REG_WIDTH'($urandom_range(1, 4095)), REG_WIDTH'($urandom_range(0, 4095)), 140);
    idling_on = 1'b0;
    run_phase(BUFFER_CAPACITY_RST, MAX_LINE_BYTES_RST, 140);

    // Drain the remaining results.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("summary: %0d input transactions, %0d lines checked", sent_items, sb.lines_checked);
    $display("summary: ok %0d, empty %0d, too long %0d, NUL %0d, control %0d, invalid %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY], sb.status_seen[ST_TOO_LONG],
             sb.status_seen[ST_NUL], sb.status_seen[ST_CONTROL], sb.status_seen[ST_INVALID]);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("error: %0d mismatches, %0d results still expected", sb.failures, sb.pending());
      $display("tb: failure");
    end
    $finish;
  end
endmodule
